/* rtl/rbd_pkg.sv */
// shared types and constants for the ring buffer deque
// no dependencies
package rbd_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int FILL_W       = 5;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic start;
		logic load;
	} ctl_cmd_t;

endpackage

/* rtl/rbd_if.sv */
// request and response channel interfaces of the ring buffer deque
// depends on rbd_pkg
interface rbd_req_if;
	logic                             valid;
	logic                             ready;
	rbd_pkg::op_t                     operation;
	logic signed [rbd_pkg::VALUE_W-1:0] push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface rbd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [rbd_pkg::VALUE_W-1:0] pop_value;
	rbd_pkg::status_t                   status;
	logic [rbd_pkg::FILL_W-1:0]         fill_count;

	modport source (output valid, output pop_value, output status, output fill_count,
		input ready);
	modport sink   (input valid, input pop_value, input status, input fill_count,
		output ready);
endinterface

/* rtl/ring_buffer_deque.sv */
// ring buffer deque top level: controller plus datapath behind valid/ready channels
// the request is registered into the read and status stage, then into the result register
// a new request is not taken while the previous one executes, because of the registered
//   read port of the element memory and the single-entry result register
// reset: arst_n clears indices, count and handshake state; the element memory is not
//   cleared, a pop only ever reads entries written by an earlier push
module ring_buffer_deque #(
	parameter int CAPACITY = rbd_pkg::CAPACITY_DEF
) (
	input logic   clk,
	input logic   arst_n,
	rbd_req_if.sink   req,
	rbd_rsp_if.source rsp
);
	import rbd_pkg::*;

	ctl_cmd_t cmd;

	// controller: accepts a request when idle and the result slot is free,
	// spends an execute state on the memory access, then loads the result register
	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: front/back indices, element count, memory and result register
	rbd_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (req.operation),
		.push_value (req.push_value),
		.pop_value  (rsp.pop_value),
		.status     (rsp.status),
		.fill_count (rsp.fill_count)
	);

	// a request is never taken on the cycle right after another
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one still executing");

	// every accepted request is followed by a valid result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> ##2 rsp.valid)
		else $error("result missing after accepted request");

	// rejected or failed operations return a zero value
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STAT_FULL || rsp.status == STAT_EMPTY))
		|-> (rsp.pop_value == '0))
		else $error("non-zero value on failed operation");

endmodule

/* rtl/rbd_ctrl.sv */
// controller of the ring buffer deque: handshake and sequencing
// depends on rbd_pkg
module rbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rbd_pkg::ctl_cmd_t cmd
);
	import rbd_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				// output slot is free or frees up at this edge
				req_ready = !rsp_valid_q || rsp_ready;
				if (req_valid && req_ready) begin
					cmd.start = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

/* rtl/rbd_datapath.sv */
// datapath of the ring buffer deque: indices, count, element memory, result register
// depends on rbd_pkg
module rbd_datapath #(
	parameter int CAPACITY = rbd_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rbd_pkg::ctl_cmd_t                  cmd,
	input  rbd_pkg::op_t                       operation,
	input  logic signed [rbd_pkg::VALUE_W-1:0] push_value,
	output logic signed [rbd_pkg::VALUE_W-1:0] pop_value,
	output rbd_pkg::status_t                   status,
	output logic [rbd_pkg::FILL_W-1:0]         fill_count
);
	import rbd_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	logic [VALUE_W-1:0] mem [CAPACITY];

	logic [IW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;

	logic [IW-1:0] front_nx, front_pv, back_nx, back_pv;
	logic          full, empty;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	logic [IW-1:0] front_d, back_d;
	logic [CW-1:0] count_d;
	status_t       status_d;

	logic [VALUE_W-1:0] rdata_s1;
	logic               pop_ok_s1;
	status_t            status_s1;

	logic [VALUE_W-1:0]   pop_value_q;
	status_t              status_q;
	logic [FILL_W-1:0]    fill_q;
	logic [CW+FILL_W-1:0] count_ext;

	assign front_nx = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_pv = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign back_nx  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
	assign back_pv  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);

	always_comb begin
		we       = 1'b0;
		re       = 1'b0;
		waddr    = back_q;
		raddr    = front_q;
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		status_d = STAT_DONE;
		case (operation)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we      = 1'b1;
					waddr   = back_q;
					back_d  = back_nx;
					count_d = count_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we      = 1'b1;
					waddr   = front_pv;
					front_d = front_pv;
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = front_q;
					front_d = front_nx;
					count_d = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = back_pv;
					back_d  = back_pv;
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				status_d = STAT_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// element memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.start && we) begin
			mem[waddr] <= push_value;
		end
		if (cmd.start && re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pop_ok_s1 <= re;
			status_s1 <= status_d;
		end
	end

	assign count_ext = {{FILL_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pop_value_q <= pop_ok_s1 ? rdata_s1 : '0;
			status_q    <= status_s1;
			fill_q      <= count_ext[FILL_W-1:0];
		end
	end

	assign pop_value  = pop_value_q;
	assign status     = status_q;
	assign fill_count = fill_q;

endmodule

/* test/rbd_deque_checker.sv */
// checker for the ring buffer deque: tracks its own copy of the deque and compares each result
// depends on rbd_pkg and the channel interfaces in rbd_if
module rbd_deque_checker #(
	parameter int CAPACITY = rbd_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	rbd_req_if  req,
	rbd_rsp_if  rsp,
	output int  mismatches,
	output int  outstanding,
	output int  requests_seen,
	output int  pushes_stored,
	output int  values_popped,
	output int  full_rejects,
	output int  empty_rejects
);
	import rbd_pkg::*;

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                   status;
		logic [FILL_W-1:0]         fill_count;
	} deque_result_t;

	logic signed [VALUE_W-1:0] slots [CAPACITY];
	int front_slot;
	int back_slot;
	int held;
	deque_result_t awaited_results [$];
	int results_seen;

	// one deque operation on the shadow copy, returns the result it should give
	function automatic deque_result_t apply_deque_op(op_t op,
			logic signed [VALUE_W-1:0] value);
		deque_result_t r;
		r.pop_value = '0;
		r.status    = STAT_DONE;
		if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
			if (held >= CAPACITY) begin
				r.status = STAT_FULL;
				full_rejects++;
			end else if (op == OP_PUSH_BACK) begin
				slots[SW'(back_slot)] = value;
				back_slot = (back_slot + 1) % CAPACITY;
				held++;
				pushes_stored++;
			end else begin
				front_slot = (front_slot + CAPACITY - 1) % CAPACITY;
				slots[SW'(front_slot)] = value;
				held++;
				pushes_stored++;
			end
		end else begin
			if (held == 0) begin
				r.status = STAT_EMPTY;
				empty_rejects++;
			end else if (op == OP_POP_FRONT) begin
				r.pop_value = slots[SW'(front_slot)];
				front_slot = (front_slot + 1) % CAPACITY;
				held--;
				values_popped++;
			end else begin
				back_slot = (back_slot + CAPACITY - 1) % CAPACITY;
				r.pop_value = slots[SW'(back_slot)];
				held--;
				values_popped++;
			end
		end
		r.fill_count = FILL_W'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		deque_result_t want;
		deque_result_t got;
		if (!arst_n) begin
			front_slot    = 0;
			back_slot     = 0;
			held          = 0;
			results_seen  = 0;
			mismatches    = 0;
			requests_seen = 0;
			pushes_stored = 0;
			values_popped = 0;
			full_rejects  = 0;
			empty_rejects = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.pop_value  = rsp.pop_value;
				got.status     = rsp.status;
				got.fill_count = rsp.fill_count;
				results_seen++;
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d arrived with no request pending: ",
							"value %0d status %s fill %0d"},
							results_seen, got.pop_value, got.status.name(), got.fill_count);
				end else begin
					want = awaited_results.pop_front();
					if (got.pop_value !== want.pop_value || got.status !== want.status ||
							got.fill_count !== want.fill_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result %0d: got value %0d status %s fill %0d, ",
								"want value %0d status %s fill %0d"},
								results_seen, got.pop_value, got.status.name(),
								got.fill_count, want.pop_value, want.status.name(),
								want.fill_count);
					end
				end
			end
			if (req.valid && req.ready) begin
				requests_seen++;
				awaited_results.push_back(apply_deque_op(req.operation, req.push_value));
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

/* test/tb_ring_buffer_deque.sv */
// top of the ring buffer deque testbench: clock, reset, request stimulus, result stalls, verdict
// depends on rbd_pkg, rbd_if, the deque rtl and rbd_deque_checker
module tb_ring_buffer_deque;
	import rbd_pkg::*;

	localparam int DEPTH           = CAPACITY_DEF;
	localparam int RANDOM_REQUESTS = 900;
	localparam int SQUEEZE_AT      = 450;   // request index where the long result stall starts
	localparam int SQUEEZE_LEN     = 30;    // back-to-back pushes offered during the stall
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake before giving up

	// receiver stall patterns
	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY} rx_mode_t;

	logic clk;
	logic arst_n;

	rbd_req_if req_ch ();
	rbd_rsp_if rsp_ch ();

	int mismatches;
	int outstanding;
	int requests_seen;
	int pushes_stored;
	int values_popped;
	int full_rejects;
	int empty_rejects;

	// set once by the stimulus, the receiver serves it with one long stall
	logic hold_off_pending;
	// requests left in the current back-to-back burst
	int burst_left;
	int idle_cycles = 0;

	ring_buffer_deque #(.CAPACITY(DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rbd_deque_checker #(.CAPACITY(DEPTH)) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.requests_seen (requests_seen),
		.pushes_stored (pushes_stored),
		.values_popped (values_popped),
		.full_rejects  (full_rejects),
		.empty_rejects (empty_rejects)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one request, called at a falling edge and returns at a falling edge
	// a random gap is put in front of the request when the current burst runs out
	task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value);
		if (burst_left == 0) begin
			req_ch.valid      = 1'b0;
			// payload noise while valid is low
			req_ch.operation  = op_t'($urandom_range(0, 3));
			req_ch.push_value = $urandom;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			// mostly short bursts, now and then a long stretch with no gaps
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
		end
		burst_left--;
		req_ch.valid      = 1'b1;
		req_ch.operation  = op;
		req_ch.push_value = value;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// request side: directed corner cases, then biased random traffic
	initial begin : stimulus
		logic signed [VALUE_W-1:0] corner_values [6];
		op_t op;
		logic signed [VALUE_W-1:0] value;
		int push_pct;
		int total_failures;

		corner_values[0] = 32'sh7FFF_FFFF;
		corner_values[1] = 32'sh8000_0000;
		corner_values[2] = 32'sh0000_0000;
		corner_values[3] = 32'shFFFF_FFFF;
		corner_values[4] = 32'shAAAA_AAAA;
		corner_values[5] = 32'sh5555_5555;

		req_ch.valid      = 1'b0;
		req_ch.operation  = OP_PUSH_BACK;
		req_ch.push_value = '0;
		hold_off_pending  = 1'b0;
		burst_left        = 0;
		push_pct          = 50;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pops on an empty deque, from either end
		send_request(OP_POP_FRONT, 32'sh1234_5678);
		send_request(OP_POP_BACK, 32'shFFFF_FFFF);
		// fill to capacity alternating ends, extreme values first
		for (int i = 0; i < DEPTH; i++) begin
			value = (i < 6) ? corner_values[3'(i)] : $urandom;
			send_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, value);
		end
		// pushes on a full deque, from either end
		send_request(OP_PUSH_BACK, 32'sh0BAD_0BAD);
		send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		// drain a few from both ends
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);

		// random part: the push bias swings so the fill level keeps hitting both walls
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			if (n == SQUEEZE_AT) begin
				// long result stall while pushes keep coming back to back
				hold_off_pending = 1'b1;
				burst_left = SQUEEZE_LEN + 10;
			end
			if (n >= SQUEEZE_AT && n < SQUEEZE_AT + SQUEEZE_LEN)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else if ($urandom_range(0, 99) < push_pct)
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			value = ($urandom_range(0, 7) == 0) ?
				corner_values[3'($urandom_range(0, 3))] : $urandom;
			send_request(op, value);
		end
		req_ch.valid = 1'b0;

		// drain: wait for every result, then a few more cycles for strays
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		total_failures = mismatches + outstanding;
		$display("covered %0d requests: %0d values stored, %0d popped",
			requests_seen, pushes_stored, values_popped);
		$display("%0d pushes refused on full, %0d pops on empty", full_rejects, empty_rejects);
		if (total_failures == 0) begin
			$display("ring_buffer_deque: match");
		end else begin
			$display("%0d failing results", total_failures);
			$display("ring_buffer_deque: mismatch");
		end
		$finish;
	end

	// result side: stall patterns that change at random intervals, plus one long hold-off
	initial begin : receiver
		rx_mode_t mode;
		int span;
		int phase;
		logic hold_off_served;

		rsp_ch.ready    = 1'b0;
		mode            = RX_OPEN;
		span            = 0;
		phase           = 0;
		hold_off_served = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_pending && !hold_off_served) begin
				hold_off_served = 1'b1;
				rsp_ch.ready = 1'b0;
				// counted here so the sender keeps pushing into a stalled block
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(10, 80);
			end
			span--;
			phase++;
			case (mode)
				RX_OPEN:        rsp_ch.ready = 1'b1;
				RX_COIN:        rsp_ch.ready = 1'($urandom_range(0, 1));
				RX_EVERY_THIRD: rsp_ch.ready = (phase % 3 == 0);
				default:        rsp_ch.ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// watchdog on stretches with no handshake on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no handshake for %0d cycles", IDLE_LIMIT);
			$display("ring_buffer_deque: mismatch");
			$finish;
		end
	end

endmodule
